// ===== design/tbmc_pkg.sv =====
// Shared types and constants for the timed blind motor controller.
`timescale 1ns / 1ps

package tbmc_pkg;

    localparam int FULL_SCALE = 100;
    localparam int PCT_W      = 7;
    localparam int MS_W       = 12;
    localparam int SECS_W     = 8;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(FULL_SCALE);
    localparam logic [PCT_W-1:0] PCT_ZERO = '0;

    // Register indexes on the configuration port.
    localparam logic [0:0] REG_OPEN_SECONDS  = 1'b0;
    localparam logic [0:0] REG_CLOSE_SECONDS = 1'b1;

    localparam logic [SECS_W-1:0] SECONDS_RESET = 8'd20;

    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_MOVE     = 3'd1,
        KIND_BTN_UP   = 3'd2,
        KIND_BTN_DOWN = 3'd3,
        KIND_SET      = 3'd4
    } kind_t;

    typedef struct packed {
        logic [PCT_W-1:0] blind_percent;
        logic [PCT_W-1:0] goal_percent;
        logic             run_active;
        logic             going_up;
        logic [MS_W-1:0]  ms_count;
        logic             first_step_done;
    } state_t;

    typedef struct packed {
        logic             motor_up;
        logic             motor_down;
        logic [PCT_W-1:0] current_percent;
        logic [PCT_W-1:0] target_percent;
        logic             moving;
        logic             notify;
    } result_t;

endpackage

// ===== design/tbmc_core.sv =====
// Blind position state and the per-beat update logic.
`timescale 1ns / 1ps

module tbmc_core
    import tbmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [2:0]        kind,
    input  logic [7:0]        position,
    input  logic [SECS_W-1:0] open_seconds,
    input  logic [SECS_W-1:0] close_seconds,
    output result_t           res
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        logic [PCT_W-1:0]  pos_c;
        logic [PCT_W-1:0]  mv_pos;
        logic [PCT_W-1:0]  step_pct;
        logic [SECS_W-1:0] secs;
        logic [MS_W-1:0]   interval;
        logic [MS_W-1:0]   ms_inc;
        logic              reached;
        logic              note;

        state_next = state_reg;
        note       = 1'b0;
        step_pct   = state_reg.blind_percent;
        reached    = 1'b0;

        pos_c = (position > 8'(FULL_SCALE)) ? PCT_FULL : position[PCT_W-1:0];

        // A button stops a move in progress, otherwise it runs to an end stop.
        if (kind_t'(kind) == KIND_MOVE)
            mv_pos = pos_c;
        else if (state_reg.blind_percent != state_reg.goal_percent)
            mv_pos = state_reg.blind_percent;
        else if (kind_t'(kind) == KIND_BTN_UP)
            mv_pos = PCT_FULL;
        else
            mv_pos = PCT_ZERO;

        secs     = state_reg.going_up ? open_seconds : close_seconds;
        // Ten ticks per second of travel time make one percent step.
        interval = {1'b0, secs, 3'b000} + {3'b000, secs, 1'b0};
        if (interval == '0)
            interval = MS_W'(1);
        ms_inc = state_reg.ms_count + MS_W'(1);

        case (kind_t'(kind))
            KIND_TICK:
            begin
                if (state_reg.run_active)
                begin
                    if (ms_inc < interval)
                        state_next.ms_count = ms_inc;
                    else
                    begin
                        state_next.ms_count = '0;
                        if (state_reg.going_up)
                        begin
                            if (state_reg.blind_percent < PCT_FULL)
                                step_pct = state_reg.blind_percent + PCT_W'(1);
                        end
                        else if (state_reg.blind_percent != PCT_ZERO)
                            step_pct = state_reg.blind_percent - PCT_W'(1);
                        state_next.blind_percent = step_pct;
                        if (!state_reg.first_step_done)
                        begin
                            state_next.first_step_done = 1'b1;
                            note = 1'b1;
                        end
                        reached = state_reg.going_up ?
                                  (step_pct >= state_reg.goal_percent) :
                                  (step_pct <= state_reg.goal_percent);
                        if (reached)
                        begin
                            state_next.run_active   = 1'b0;
                            state_next.goal_percent = step_pct;
                            note = 1'b1;
                        end
                    end
                end
            end
            KIND_MOVE, KIND_BTN_UP, KIND_BTN_DOWN:
            begin
                if (state_reg.run_active)
                begin
                    state_next.run_active   = 1'b0;
                    state_next.goal_percent = state_reg.blind_percent;
                    note = 1'b1;
                end
                else
                begin
                    state_next.goal_percent = mv_pos;
                    if (mv_pos == state_reg.blind_percent)
                        note = 1'b1;
                    else
                    begin
                        state_next.going_up        = mv_pos > state_reg.blind_percent;
                        state_next.run_active      = 1'b1;
                        state_next.ms_count        = '0;
                        state_next.first_step_done = 1'b0;
                    end
                end
                if (kind_t'(kind) != KIND_MOVE)
                    note = 1'b1;
            end
            KIND_SET:
            begin
                if (!state_reg.run_active)
                begin
                    state_next.blind_percent = pos_c;
                    state_next.goal_percent  = pos_c;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        res.motor_up        = state_next.run_active && state_next.going_up;
        res.motor_down      = state_next.run_active && !state_next.going_up;
        res.current_percent = state_next.blind_percent;
        res.target_percent  = state_next.goal_percent;
        res.moving          = state_next.run_active;
        res.notify          = note;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step_en)
            state_reg <= state_next;
    end

endmodule

// ===== design/timed_blind_motor_controller.sv =====
// Top level of the timed blind motor controller: input stage, registers, result stage.
`timescale 1ns / 1ps

// Each input beat (tick, move, button or set-position) yields exactly one result
// beat. The block takes one beat per clock cycle, sustained, as long as results are
// taken; a beat is held in the input register, and its result is computed from it and
// registered in the output register once that register is free. The position
// update is a single compare-and-increment pass between those two registers, which
// sets the one-beat-per-cycle figure. There is no clearing pass after reset.
module timed_blind_motor_controller
    import tbmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        kind,
    input  logic [7:0]        position,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              motor_up,
    output logic              motor_down,
    output logic [PCT_W-1:0]  current_percent,
    output logic [PCT_W-1:0]  target_percent,
    output logic              moving,
    output logic              notify,
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_addr,
    input  logic [SECS_W-1:0] cfg_wr_data
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [2:0]        s1_kind_reg;
    logic [7:0]        s1_pos_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_res_reg;
    result_t           step_res;
    logic [SECS_W-1:0] open_seconds_reg;
    logic [SECS_W-1:0] close_seconds_reg;
    logic              s1_adv;
    logic              in_accept;

    // The input stage moves on whenever the result register is empty or drained.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= kind;
            s1_pos_reg  <= position;
        end
        if (s1_adv)
            out_res_reg <= step_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_seconds_reg  <= SECONDS_RESET;
            close_seconds_reg <= SECONDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_OPEN_SECONDS:  open_seconds_reg  <= cfg_wr_data;
                REG_CLOSE_SECONDS: close_seconds_reg <= cfg_wr_data;
                default:           open_seconds_reg  <= open_seconds_reg;
            endcase
        end
    end

    tbmc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (s1_adv),
        .kind          (s1_kind_reg),
        .position      (s1_pos_reg),
        .open_seconds  (open_seconds_reg),
        .close_seconds (close_seconds_reg),
        .res           (step_res)
    );

    assign out_valid       = out_valid_reg;
    assign motor_up        = out_res_reg.motor_up;
    assign motor_down      = out_res_reg.motor_down;
    assign current_percent = out_res_reg.current_percent;
    assign target_percent  = out_res_reg.target_percent;
    assign moving          = out_res_reg.moving;
    assign notify          = out_res_reg.notify;

`ifndef SYNTHESIS
    a_relay_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(motor_up && motor_down))
        else $error("up and down relays driven together");

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (current_percent <= PCT_FULL) && (target_percent <= PCT_FULL))
        else $error("position beyond full scale");

    a_idle_on_target: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !moving) |-> (current_percent == target_percent))
        else $error("idle blind not at its target");

    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && s1_valid_reg) |-> in_stall)
        else $error("input taken while both stages are full and blocked");
`endif

endmodule
